// ----- rtl/jitl_pkg.sv -----
// Shared types, constants and helper functions for the joint impedance torque law core.
package jitl_pkg;

    // Port widths
    localparam int S_TDATA_W = 168;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 72;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 31;

    // Accumulator width: largest sum is just over 2^48
    localparam int ACC_W = 50;

    // Filter weights, Q0.16, summing to one
    localparam logic [31:0] FILT_OLD_W = 32'd655;
    localparam logic [31:0] FILT_NEW_W = 32'd64881;
    localparam logic [16:0] Q16_ONE = 17'd65536;
    localparam logic [17:0] CW_MAX = 18'd131072;
    localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(32768);

    // Commands carried in tuser
    typedef enum logic [2:0] {
        CMD_TICK      = 3'd0,
        CMD_START     = 3'd1,
        CMD_TARGET    = 3'd2,
        CMD_GAIN_GOAL = 3'd3,
        CMD_GAIN_LOAD = 3'd4
    } cmd_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CORIOLIS_WEIGHT = 2'd0,
        REG_TORQUE_LIMIT    = 2'd1,
        REG_GAIN_BLEND      = 2'd2
    } reg_idx_t;

    // One joint's state, one memory row
    typedef struct packed {
        logic signed [31:0] fv;
        logic signed [31:0] tp;
        logic signed [31:0] tv;
        logic signed [31:0] sp;
        logic [31:0]        k_now;
        logic [31:0]        d_now;
        logic [31:0]        k_goal;
        logic [31:0]        d_goal;
    } row_t;

    // Accumulator selector for a multiply
    typedef enum logic [1:0] {
        DST_FILT = 2'd0,
        DST_TQ   = 2'd1,
        DST_KB   = 2'd2,
        DST_DB   = 2'd3
    } mac_dst_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] a;
        logic [31:0] b;
        logic        neg;
        mac_dst_t    dst;
    } mac_op_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] filt;
        logic signed [ACC_W-1:0] tq;
        logic [ACC_W-1:0]        kb;
        logic [ACC_W-1:0]        db;
    } mac_acc_t;

    // Magnitude of a signed 32-bit value; -2^31 maps to 2^31
    function automatic logic [31:0] abs32(input logic signed [31:0] x);
        abs32 = x[31] ? (~x + 32'd1) : x;
    endfunction

    // Saturate a 33-bit signed difference to 32 bits
    function automatic logic signed [31:0] sat33(input logic signed [32:0] d);
        if (d[32] != d[31]) begin
            sat33 = d[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            sat33 = d[31:0];
        end
    endfunction

endpackage

// ----- rtl/jitl_row_ram.sv -----
// Per-joint state memory: one write port, one registered read port.
module jitl_row_ram #(
    parameter int DEPTH = 7,
    parameter int AW = 3
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  jitl_pkg::row_t   wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output jitl_pkg::row_t   rd_data
);
    import jitl_pkg::*;

    row_t mem [DEPTH];
    row_t rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/jitl_mac.sv -----
// Shared 32x32 multiplier with registered product and four accumulators.
module jitl_mac (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                clear,
    input  jitl_pkg::mac_op_t   op,
    output jitl_pkg::mac_acc_t  acc
);
    import jitl_pkg::*;

    logic [63:0]      prod_reg;
    logic             prod_valid_reg;
    logic             prod_neg_reg;
    mac_dst_t         prod_dst_reg;
    mac_acc_t         acc_reg;
    logic [47:0]      tq_term;
    logic [ACC_W-1:0] prod_ext;
    logic [ACC_W-1:0] tq_ext;

    // Multiply stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
        end else begin
            prod_valid_reg <= op.valid;
        end
        prod_reg     <= 64'(op.a) * 64'(op.b);
        prod_neg_reg <= op.neg;
        prod_dst_reg <= op.dst;
    end

    // Torque terms are rounded half away from zero on the magnitude
    assign tq_term  = 48'((prod_reg + 64'd32768) >> 16);
    assign tq_ext   = ACC_W'(tq_term);
    assign prod_ext = ACC_W'(prod_reg);

    // Accumulate stage
    always_ff @(posedge aclk) begin
        if (clear) begin
            acc_reg <= '0;
        end else if (prod_valid_reg) begin
            case (prod_dst_reg)
                DST_FILT: begin
                    acc_reg.filt <= prod_neg_reg ? acc_reg.filt - signed'(prod_ext)
                                                 : acc_reg.filt + signed'(prod_ext);
                end
                DST_TQ: begin
                    acc_reg.tq <= prod_neg_reg ? acc_reg.tq - signed'(tq_ext)
                                               : acc_reg.tq + signed'(tq_ext);
                end
                DST_KB: begin
                    acc_reg.kb <= acc_reg.kb + prod_ext;
                end
                DST_DB: begin
                    acc_reg.db <= acc_reg.db + prod_ext;
                end
                default: begin
                    acc_reg <= acc_reg;
                end
            endcase
        end
    end

    assign acc = acc_reg;

endmodule

// ----- rtl/joint_impedance_torque_law_core.sv -----
// Top level: command sequencer, configuration registers and output word register.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+--------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tdata joint..damping, s_tuser cmd
//  m_      | out | m_tvalid/m_tready  | m_tdata out_joint, torque, pos error, clamped
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A tick word goes through a memory read, the single shared multiplier
// (nine products plus a drain) and a finish step that writes the row back.
// Other commands read, modify and write back the row; a word for an absent
// joint or an unknown command is accepted and changes nothing.
// Reset (aresetn low, synchronous) clears the per-joint valid bits, so every
// joint reads as all zero until first written; no clearing pass is needed.
// A result waiting on m_tready holds only the finish cycle of the next tick.
module joint_impedance_torque_law_core #(
    parameter int JOINT_COUNT = 7
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // joint[2:0], position[34:3], velocity[66:35], coriolis_torque[98:67],
    // tq_mode[99], length_ok[100], stiffness_value[132:101],
    // damping_value[164:133], zero fill [167:165]
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [jitl_pkg::S_TDATA_W-1:0]      s_tdata,
    // cmd[2:0]
    input  logic [jitl_pkg::S_TUSER_W-1:0]      s_tuser,
    // out_joint[2:0], torque[34:3], position_error[66:35], clamped[67],
    // zero fill [71:68]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [jitl_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [jitl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [jitl_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import jitl_pkg::*;

    localparam int IDX_W = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_FIN
    } state_t;

    // Input word fields
    logic [2:0]         s_joint;
    logic signed [31:0] s_pos;
    logic signed [31:0] s_vel;
    logic signed [31:0] s_cor;
    logic               s_mode;
    logic               s_lenok;
    logic [31:0]        s_kval;
    logic [31:0]        s_dval;
    logic [7:0]         s_joint_ext;
    logic [IDX_W-1:0]   s_addr;
    logic               s_in_range;
    logic               s_cmd_known;
    logic               s_accept;

    assign s_joint     = s_tdata[2:0];
    assign s_pos       = s_tdata[34:3];
    assign s_vel       = s_tdata[66:35];
    assign s_cor       = s_tdata[98:67];
    assign s_mode      = s_tdata[99];
    assign s_lenok     = s_tdata[100];
    assign s_kval      = s_tdata[132:101];
    assign s_dval      = s_tdata[164:133];
    assign s_joint_ext = {5'd0, s_joint};
    assign s_addr      = s_joint_ext[IDX_W-1:0];
    assign s_in_range  = s_joint_ext < 8'(JOINT_COUNT);

    always_comb begin
        s_cmd_known = s_tuser inside {CMD_TICK, CMD_START, CMD_TARGET, CMD_GAIN_GOAL,
                                      CMD_GAIN_LOAD};
    end

    // Registers
    state_t             state_reg;
    logic [3:0]         cnt_reg;
    logic [JOINT_COUNT-1:0] row_valid_reg;
    logic [17:0]        coriolis_weight_reg;
    logic [30:0]        torque_limit_reg;
    logic [16:0]        gain_blend_reg;

    logic [2:0]         cmd_reg;
    logic [2:0]         joint_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic signed [31:0] pos_reg;
    logic signed [31:0] vel_reg;
    logic               mode_reg;
    logic               lenok_reg;
    logic [31:0]        kval_reg;
    logic [31:0]        dval_reg;
    logic [31:0]        vel_mag_reg;
    logic               vel_neg_reg;
    logic [31:0]        cor_mag_reg;
    logic               cor_neg_reg;

    row_t               row_reg;
    logic signed [31:0] perr_reg;
    logic [31:0]        perr_mag_reg;
    logic               perr_neg_reg;
    logic [31:0]        fold_mag_reg;
    logic               fold_neg_reg;
    logic [31:0]        filt_rmag_reg;
    logic               filt_neg_reg;
    logic signed [31:0] fnew_reg;
    logic signed [31:0] verr_reg;
    logic [31:0]        verr_mag_reg;
    logic               verr_neg_reg;

    logic               m_tvalid_reg;
    logic [2:0]         m_joint_reg;
    logic signed [31:0] m_torque_reg;
    logic signed [31:0] m_perr_reg;
    logic               m_clamped_reg;

    // Memory and multiplier hookup
    logic       ram_wr_en;
    row_t       ram_wr_data;
    row_t       ram_rd_data;
    mac_op_t    mac_op;
    mac_acc_t   mac_acc;

    jitl_row_ram #(
        .DEPTH (JOINT_COUNT),
        .AW    (IDX_W)
    ) u_row_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (idx_reg),
        .wr_data (ram_wr_data),
        .rd_en   (s_accept),
        .rd_addr (s_addr),
        .rd_data (ram_rd_data)
    );

    jitl_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (state_reg == ST_LOAD),
        .op      (mac_op),
        .acc     (mac_acc)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Effective register values, oversize settings pinned to full scale
    logic [17:0] cw_eff;
    logic [16:0] gb_eff;
    logic [16:0] gb_inv;

    assign cw_eff = (coriolis_weight_reg > CW_MAX) ? CW_MAX : coriolis_weight_reg;
    assign gb_eff = (gain_blend_reg > Q16_ONE) ? Q16_ONE : gain_blend_reg;
    assign gb_inv = Q16_ONE - gb_eff;

    // Row as read; a never-written joint reads as zero
    row_t row_cur;
    assign row_cur = row_valid_reg[idx_reg] ? ram_rd_data : '0;

    // Non-tick commands applied to the row
    row_t row_mod;
    always_comb begin
        row_mod = row_cur;
        case (cmd_reg)
            CMD_START: begin
                row_mod.sp = pos_reg;
                row_mod.tp = pos_reg;
                row_mod.fv = '0;
                row_mod.tv = '0;
            end
            CMD_TARGET: begin
                if (mode_reg) begin
                    if (!lenok_reg) begin
                        row_mod.tp = row_cur.sp;
                    end else begin
                        row_mod.tp = pos_reg;
                        row_mod.tv = vel_reg;
                    end
                end
            end
            CMD_GAIN_GOAL: begin
                row_mod.k_goal = kval_reg;
                row_mod.d_goal = dval_reg;
            end
            CMD_GAIN_LOAD: begin
                row_mod.k_now  = kval_reg;
                row_mod.d_now  = dval_reg;
                row_mod.k_goal = kval_reg;
                row_mod.d_goal = dval_reg;
            end
            default: begin
                row_mod = row_cur;
            end
        endcase
    end

    // Multiply schedule over the tick
    always_comb begin
        mac_op = '0;
        if (state_reg == ST_MUL) begin
            case (cnt_reg)
                4'd0: mac_op = '{1'b1, FILT_OLD_W, fold_mag_reg, fold_neg_reg, DST_FILT};
                4'd1: mac_op = '{1'b1, FILT_NEW_W, vel_mag_reg, vel_neg_reg, DST_FILT};
                4'd2: mac_op = '{1'b1, 32'(cw_eff), cor_mag_reg, cor_neg_reg, DST_TQ};
                4'd3: mac_op = '{1'b1, row_reg.k_now, perr_mag_reg, perr_neg_reg, DST_TQ};
                4'd4: mac_op = '{1'b1, 32'(gb_eff), row_reg.k_goal, 1'b0, DST_KB};
                4'd5: mac_op = '{1'b1, 32'(gb_inv), row_reg.k_now, 1'b0, DST_KB};
                4'd6: mac_op = '{1'b1, 32'(gb_eff), row_reg.d_goal, 1'b0, DST_DB};
                4'd7: mac_op = '{1'b1, 32'(gb_inv), row_reg.d_now, 1'b0, DST_DB};
                4'd8: mac_op = '{1'b1, row_reg.d_now, verr_mag_reg, verr_neg_reg, DST_TQ};
                default: mac_op = '0;
            endcase
        end
    end

    // Filter rounding: magnitude, round half up, keep sign
    logic [ACC_W-1:0] filt_abs;
    logic [ACC_W-1:0] filt_rsum;
    assign filt_abs  = mac_acc.filt[ACC_W-1] ? ACC_W'(-mac_acc.filt) : ACC_W'(mac_acc.filt);
    assign filt_rsum = filt_abs + ROUND_HALF;

    // Torque clamp and gain blend results
    logic signed [ACC_W-1:0] lim_pos;
    logic signed [ACC_W-1:0] lim_neg;
    logic signed [31:0]      torque_fin;
    logic                    clip_fin;
    logic [ACC_W-1:0]        kb_sum;
    logic [ACC_W-1:0]        db_sum;
    row_t                    row_fin;

    assign lim_pos = signed'(ACC_W'(torque_limit_reg));
    assign lim_neg = -lim_pos;
    assign kb_sum  = mac_acc.kb + ROUND_HALF;
    assign db_sum  = mac_acc.db + ROUND_HALF;

    always_comb begin
        if (mac_acc.tq > lim_pos) begin
            torque_fin = lim_pos[31:0];
            clip_fin   = 1'b1;
        end else if (mac_acc.tq < lim_neg) begin
            torque_fin = lim_neg[31:0];
            clip_fin   = 1'b1;
        end else begin
            torque_fin = mac_acc.tq[31:0];
            clip_fin   = 1'b0;
        end
        row_fin       = row_reg;
        row_fin.fv    = fnew_reg;
        row_fin.k_now = kb_sum[47:16];
        row_fin.d_now = db_sum[47:16];
    end

    // Row write-back
    logic out_free;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_data = row_mod;
        if (state_reg == ST_LOAD && cmd_reg != CMD_TICK) begin
            ram_wr_en = 1'b1;
        end else if (state_reg == ST_FIN && out_free) begin
            ram_wr_en   = 1'b1;
            ram_wr_data = row_fin;
        end
    end

    // Sequencer, configuration and output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= ST_IDLE;
            cnt_reg             <= '0;
            row_valid_reg       <= '0;
            m_tvalid_reg        <= 1'b0;
            coriolis_weight_reg <= 18'd65536;
            torque_limit_reg    <= 31'd65536;
            gain_blend_reg      <= 17'd328;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_CORIOLIS_WEIGHT: coriolis_weight_reg <= cfg_data[17:0];
                    REG_TORQUE_LIMIT:    torque_limit_reg    <= cfg_data[30:0];
                    REG_GAIN_BLEND:      gain_blend_reg      <= cfg_data[16:0];
                    default: ;
                endcase
            end

            // Output valid: a new word replaces a taken one in the same cycle
            if (state_reg == ST_FIN && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        cmd_reg     <= s_tuser;
                        joint_reg   <= s_joint;
                        idx_reg     <= s_addr;
                        pos_reg     <= s_pos;
                        vel_reg     <= s_vel;
                        mode_reg    <= s_mode;
                        lenok_reg   <= s_lenok;
                        kval_reg    <= s_kval;
                        dval_reg    <= s_dval;
                        vel_mag_reg <= abs32(s_vel);
                        vel_neg_reg <= s_vel[31];
                        cor_mag_reg <= abs32(s_cor);
                        cor_neg_reg <= s_cor[31];
                        if (s_in_range && s_cmd_known) begin
                            state_reg <= ST_LOAD;
                        end
                    end
                end
                ST_LOAD: begin
                    row_reg      <= row_cur;
                    perr_reg     <= sat33(33'(row_cur.tp) - 33'(pos_reg));
                    fold_mag_reg <= abs32(row_cur.fv);
                    fold_neg_reg <= row_cur.fv[31];
                    cnt_reg      <= '0;
                    if (cmd_reg == CMD_TICK) begin
                        state_reg <= ST_MUL;
                    end else begin
                        row_valid_reg[idx_reg] <= 1'b1;
                        state_reg              <= ST_IDLE;
                    end
                end
                ST_MUL: begin
                    cnt_reg <= cnt_reg + 4'd1;
                    case (cnt_reg)
                        4'd0: begin
                            perr_mag_reg <= abs32(perr_reg);
                            perr_neg_reg <= perr_reg[31];
                        end
                        4'd3: begin
                            filt_rmag_reg <= filt_rsum[47:16];
                            filt_neg_reg  <= mac_acc.filt[ACC_W-1];
                        end
                        4'd4: begin
                            if (filt_neg_reg) begin
                                fnew_reg <= -signed'(filt_rmag_reg);
                            end else if (filt_rmag_reg[31]) begin
                                fnew_reg <= 32'sh7FFF_FFFF;
                            end else begin
                                fnew_reg <= signed'(filt_rmag_reg);
                            end
                        end
                        4'd5: begin
                            verr_reg <= sat33(33'(row_reg.tv) - 33'(fnew_reg));
                        end
                        4'd6: begin
                            verr_mag_reg <= abs32(verr_reg);
                            verr_neg_reg <= verr_reg[31];
                        end
                        4'd9: begin
                            state_reg <= ST_FIN;
                        end
                        default: ;
                    endcase
                end
                ST_FIN: begin
                    if (out_free) begin
                        m_joint_reg            <= joint_reg;
                        m_torque_reg           <= torque_fin;
                        m_perr_reg             <= perr_reg;
                        m_clamped_reg          <= clip_fin;
                        row_valid_reg[idx_reg] <= 1'b1;
                        state_reg              <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'd0, m_clamped_reg, m_perr_reg, m_torque_reg, m_joint_reg};

endmodule
